// ===== src/swmf_pkg.sv =====
package swmf_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int POS_BITS = 28;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int BASE_W = 8;
  localparam int WLEN_W = 7;
  localparam int DIFF_W = 6;
  localparam int TOTAL_W = 7;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = WLEN_W'(25);
  localparam logic [DIFF_W-1:0] MAX_DIFF_RST = DIFF_W'(3);

  typedef enum logic [0:0] {
    REG_WINDOW_LEN = 1'b0,
    REG_MAX_DIFF   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [BASE_W-1:0]   target_base;
    logic [BASE_W-1:0]   query_base;
    logic                first_of_region;
    logic [POS_BITS-1:0] region_target_start;
    logic [POS_BITS-1:0] region_query_start;
  } in_word_t;

  typedef struct packed {
    logic                window_full;
    logic                is_hit;
    logic [POS_BITS-1:0] hit_target_pos;
    logic [POS_BITS-1:0] hit_query_pos;
    logic [TOTAL_W-1:0]  mismatch_total;
  } out_word_t;

  typedef struct packed {
    logic [WLEN_W-1:0] window_len;
    logic [DIFF_W-1:0] max_diff;
    logic              len_wr;
  } cfg_ctl_t;

  function automatic logic [CNT_W-1:0] eff_len(input logic [WLEN_W-1:0] wl);
    logic [CNT_W-1:0] len;
    if (wl == '0) begin
      len = CNT_W'(1);
    end else if (int'(wl) > MAX_WINDOW) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(wl);
    end
    return len;
  endfunction

endpackage

// ===== src/sliding_window_mismatch_filter.sv =====
// An accepted word waits in the input register (inq), then its result is
// registered. One word per cycle; result_stall holds a waiting result
// and one held word, and a window_len write stops intake (busy) while
// the effective window length (1 to 64) is recounted.
// Reset (rst, synchronous) empties both stages, clears the window and origins,
// and sets window_len to 25 and max_diff to 3.
module sliding_window_mismatch_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  swmf_pkg::in_word_t          item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output swmf_pkg::out_word_t         result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swmf_pkg::ADDR_W-1:0] paddr,
  input  logic [swmf_pkg::DATA_W-1:0] pwdata,
  output logic [swmf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  swmf_pkg::cfg_ctl_t  ctl;
  swmf_pkg::in_word_t  inq;
  swmf_pkg::out_word_t core_result;
  logic                inq_valid;
  logic                busy;
  logic                blocked;
  logic                step;
  logic                accept;

  assign blocked = result_valid & result_stall;
  assign step = inq_valid & ~blocked & ~busy;
  assign item_stall = busy | (inq_valid & blocked);
  assign accept = item_valid & ~item_stall;

  swmf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  swmf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (inq),
    .step   (step),
    .result (core_result),
    .busy   (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      inq_valid <= accept | (inq_valid & ~step);
      result_valid <= step | blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inq <= item;
    end
    if (step) begin
      result <= core_result;
    end
  end

  a_hit_needs_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_hit |-> result.window_full)
    else $error("hit flagged on a partial window");

endmodule

// ===== src/swmf_cfg.sv =====
module swmf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [swmf_pkg::DATA_W-1:0]   pwdata,
  output logic [swmf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output swmf_pkg::cfg_ctl_t            ctl
);

  logic [swmf_pkg::WLEN_W-1:0] window_len;
  logic [swmf_pkg::DIFF_W-1:0] max_diff;
  logic                        len_wr;
  logic                        wr;
  swmf_pkg::reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite & pready;
  assign idx = swmf_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swmf_pkg::WINDOW_LEN_RST;
      max_diff <= swmf_pkg::MAX_DIFF_RST;
      len_wr <= 1'b0;
    end else begin
      len_wr <= wr && (idx == swmf_pkg::REG_WINDOW_LEN);
      if (wr) begin
        case (idx)
          swmf_pkg::REG_WINDOW_LEN: window_len <= pwdata[swmf_pkg::WLEN_W-1:0];
          swmf_pkg::REG_MAX_DIFF: max_diff <= pwdata[swmf_pkg::DIFF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      swmf_pkg::REG_WINDOW_LEN: prdata = swmf_pkg::DATA_W'(window_len);
      swmf_pkg::REG_MAX_DIFF: prdata = swmf_pkg::DATA_W'(max_diff);
      default: prdata = '0;
    endcase
  end

  assign ctl.window_len = window_len;
  assign ctl.max_diff = max_diff;
  assign ctl.len_wr = len_wr;

endmodule

// ===== src/swmf_core.sv =====
module swmf_core (
  input  logic                clk,
  input  logic                rst,
  input  swmf_pkg::cfg_ctl_t  ctl,
  input  swmf_pkg::in_word_t  item,
  input  logic                step,
  output swmf_pkg::out_word_t result,
  output logic                busy
);

  localparam logic [swmf_pkg::POS_BITS-1:0] POS_MAX = '1;

  logic [swmf_pkg::MAX_WINDOW-1:0] line;
  logic [swmf_pkg::MAX_WINDOW-1:0] scratch;
  logic [swmf_pkg::CNT_W-1:0]      count;
  logic [swmf_pkg::CNT_W-1:0]      left;
  logic [swmf_pkg::POS_BITS-1:0]   items;
  logic [swmf_pkg::POS_BITS-1:0]   target_origin;
  logic [swmf_pkg::POS_BITS-1:0]   query_origin;

  logic [swmf_pkg::CNT_W-1:0]      len;
  logic [swmf_pkg::CNT_W-1:0]      len_m1;
  logic [swmf_pkg::MAX_WINDOW-1:0] base_line;
  logic [swmf_pkg::MAX_WINDOW-1:0] line_next;
  logic [swmf_pkg::CNT_W-1:0]      base_cnt;
  logic [swmf_pkg::CNT_W-1:0]      count_next;
  logic [swmf_pkg::POS_BITS-1:0]   items_base;
  logic [swmf_pkg::POS_BITS-1:0]   items_next;
  logic [swmf_pkg::POS_BITS-1:0]   t_org;
  logic [swmf_pkg::POS_BITS-1:0]   q_org;
  logic [swmf_pkg::POS_BITS-1:0]   off;
  logic                            mbit;
  logic                            leave;
  logic                            full;

  assign busy = ctl.len_wr | (left != '0);

  always_comb begin
    len = swmf_pkg::eff_len(ctl.window_len);
    len_m1 = len - swmf_pkg::CNT_W'(1);
    base_line = item.first_of_region ? '0 : line;
    base_cnt = item.first_of_region ? '0 : count;
    mbit = item.target_base != item.query_base;
    leave = base_line[len_m1[swmf_pkg::IDX_W-1:0]];
    line_next = {base_line[swmf_pkg::MAX_WINDOW-2:0], mbit};
    count_next = base_cnt + swmf_pkg::CNT_W'(mbit) - swmf_pkg::CNT_W'(leave);
    items_base = item.first_of_region ? '0 : items;
    items_next = (items_base == POS_MAX) ? items_base
                                         : items_base + swmf_pkg::POS_BITS'(1);
    t_org = item.first_of_region ? item.region_target_start : target_origin;
    q_org = item.first_of_region ? item.region_query_start : query_origin;
    full = items_next >= swmf_pkg::POS_BITS'(len);
    off = items_next - swmf_pkg::POS_BITS'(len);
    result.window_full = full;
    result.is_hit = full && (32'(count_next) <= 32'(ctl.max_diff));
    result.hit_target_pos = full ? t_org + off : '0;
    result.hit_query_pos = full ? q_org + off : '0;
    result.mismatch_total = swmf_pkg::TOTAL_W'(count_next);
  end

  // advance the window on each step; recount the window after a length change, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      line <= '0;
      count <= '0;
      left <= '0;
      items <= '0;
      target_origin <= '0;
      query_origin <= '0;
    end else if (step) begin
      line <= line_next;
      count <= count_next;
      items <= items_next;
      target_origin <= t_org;
      query_origin <= q_org;
    end else if (ctl.len_wr) begin
      count <= '0;
      left <= len;
    end else if (left != '0) begin
      count <= count + swmf_pkg::CNT_W'(scratch[0]);
      left <= left - swmf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.len_wr) begin
      scratch <= line;
    end else if (left != '0) begin
      scratch <= scratch >> 1;
    end
  end

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    !busy |-> count <= len)
    else $error("mismatch count exceeds window length");

  a_region_restart: assert property (@(posedge clk) disable iff (rst)
    step && item.first_of_region |=> count == swmf_pkg::CNT_W'($past(mbit)))
    else $error("count not restarted at region start");

endmodule
